[src/md4_pkg.sv]
// MD4 hash engine package: state type, MD4 constants and small helper functions.
// Used by the step unit and the top level; depends on nothing else.
`default_nettype none

package md4_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_PREP,
    ST_COMP,
    ST_ADD,
    ST_RESULT
  } md4_state_e;

  localparam logic [31:0] INIT_A   = 32'h67452301;
  localparam logic [31:0] INIT_B   = 32'hefcdab89;
  localparam logic [31:0] INIT_C   = 32'h98badcfe;
  localparam logic [31:0] INIT_D   = 32'h10325476;
  localparam logic [31:0] K_ROUND2 = 32'h5A827999;
  localparam logic [31:0] K_ROUND3 = 32'h6ED9EBA1;
  localparam logic [31:0] PAD_WORD = 32'h00000080;

  localparam logic [1:0] RND_F = 2'd0;
  localparam logic [1:0] RND_G = 2'd1;
  localparam logic [1:0] RND_H = 2'd2;

  localparam logic [5:0] LAST_STEP = 6'd47;
  localparam logic [3:0] LEN_SLOT  = 4'd14;
  localparam logic [3:0] TOP_SLOT  = 4'd15;
  localparam logic [2:0] FULL_BYTES = 3'd4;

  // Message word used by a compression step.
  function automatic logic [3:0] msg_index(input logic [5:0] step);
    logic [3:0] j;
    logic [3:0] idx;
    j = step[3:0];
    case (step[5:4])
      RND_F:   idx = j;
      RND_G:   idx = {j[1:0], j[3:2]};
      RND_H:   idx = {j[0], j[1], j[2], j[3]};
      default: idx = j;
    endcase
    return idx;
  endfunction

  // Left rotate amount of a step.
  function automatic logic [4:0] shift_amt(input logic [1:0] rnd, input logic [1:0] j);
    logic [4:0] s;
    s = 5'd3;
    case (rnd)
      RND_F: begin
        case (j)
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd7;
          2'd2:    s = 5'd11;
          default: s = 5'd19;
        endcase
      end
      RND_G: begin
        case (j)
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd5;
          2'd2:    s = 5'd9;
          default: s = 5'd13;
        endcase
      end
      default: begin
        case (j)
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd9;
          2'd2:    s = 5'd11;
          default: s = 5'd15;
        endcase
      end
    endcase
    return s;
  endfunction

  // Final data word: keeps the valid low bytes and puts the pad byte after them; a full word is kept as is.
  function automatic logic [31:0] tail_word(input logic [31:0] data, input logic [2:0] nbytes);
    logic [31:0] w;
    case (nbytes)
      3'd0:    w = 32'h00000080;
      3'd1:    w = {16'h0000, 8'h80, data[7:0]};
      3'd2:    w = {8'h00, 8'h80, data[15:0]};
      3'd3:    w = {8'h80, data[23:0]};
      default: w = data;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[src/md4_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the MD4 message block; no dependencies.
`default_nettype none

module md4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire  [$clog2(DEPTH)-1:0]  waddr_i,
  input  wire  [WIDTH-1:0]          wdata_i,
  input  wire  [$clog2(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[src/md4_step.sv]
// One MD4 compression step: round function, constant add and left rotate.
// Depends on md4_pkg for round codes and the rotate table.
`default_nettype none

module md4_step (
  input  wire  [31:0] a_i,
  input  wire  [31:0] b_i,
  input  wire  [31:0] c_i,
  input  wire  [31:0] d_i,
  input  wire  [31:0] m_i,
  input  wire  [5:0]  step_i,
  output logic [31:0] a_o
);

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] sum;
  logic [63:0] rot;
  logic [4:0]  amt;

  always_comb begin
    case (step_i[5:4])
      md4_pkg::RND_F: begin
        f = d_i ^ (b_i & (c_i ^ d_i));
        k = 32'h0;
      end
      md4_pkg::RND_G: begin
        f = (b_i & c_i) | (b_i & d_i) | (c_i & d_i);
        k = md4_pkg::K_ROUND2;
      end
      default: begin
        f = b_i ^ c_i ^ d_i;
        k = md4_pkg::K_ROUND3;
      end
    endcase
    amt = md4_pkg::shift_amt(step_i[5:4], step_i[1:0]);
    sum = a_i + f + m_i + k;
    rot = {sum, sum} << amt;
    a_o = rot[63:32];
  end

endmodule

`default_nettype wire

[src/md4_hash_engine.sv]
// MD4 hash engine top level: sequencer, chaining and working registers, padding.
// Depends on md4_pkg, md4_ram and md4_step.
`default_nettype none

// A full non-last data word is taken while the input is ready. Every sixteenth word starts a
// block compression (a load of the working registers, 48 MD4 steps through the single
// step unit at one step a cycle, one chain add), during which the input is not ready.
// A last word writes the padding and length one word per cycle and runs one or two
// compressions before the digest beat is offered. A short non-last word is dropped
// and answered with an error beat whose digest is zero. The result sits in an output
// register, so the next message may start while a digest waits to be taken.
module md4_hash_engine (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [39:0]  s_axis_tdata,   // [31:0] data_word, [34:32] bytes_valid, rest zero
  input  wire          s_axis_tlast,   // last_word
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [127:0] m_axis_tdata,   // [63:0] digest_low, [127:64] digest_high
  output logic         m_axis_tuser    // error
);

  md4_pkg::md4_state_e state_q, state_d;

  logic [31:0] chain_q [4];
  logic [31:0] wa_q, wb_q, wc_q, wd_q;
  logic [63:0] byte_total_q;
  logic [3:0]  fill_q;
  logic [5:0]  step_q;
  logic        pad80_q, len_hi_q, final_q, closing_q, err_q;
  logic        out_valid_q, out_err_q;
  logic [63:0] out_low_q, out_high_q;

  logic        accept;
  logic [31:0] in_word;
  logic [2:0]  in_bytes;
  logic        short_word;
  logic        push;
  logic [31:0] push_word;
  logic [3:0]  raddr;
  logic [31:0] rdata;
  logic [31:0] step_out;
  logic [63:0] bit_len;
  logic [5:0]  step_next;
  logic        slot_free;

  assign in_word    = s_axis_tdata[31:0];
  assign in_bytes   = (s_axis_tdata[34:32] > md4_pkg::FULL_BYTES) ? md4_pkg::FULL_BYTES
                                                                  : s_axis_tdata[34:32];
  assign accept     = s_axis_tvalid && s_axis_tready;
  assign short_word = !s_axis_tlast && (in_bytes != md4_pkg::FULL_BYTES);
  assign bit_len    = {byte_total_q[60:0], 3'b000};
  assign step_next  = step_q + 6'd1;
  assign slot_free  = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == md4_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_high_q, out_low_q};
  assign m_axis_tuser  = out_err_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      md4_pkg::ST_IDLE: begin
        if (accept) begin
          if (short_word) begin
            state_d = md4_pkg::ST_RESULT;
          end else if (fill_q == md4_pkg::TOP_SLOT) begin
            state_d = md4_pkg::ST_PREP;
          end else if (s_axis_tlast) begin
            state_d = md4_pkg::ST_PAD;
          end
        end
      end
      md4_pkg::ST_PAD: begin
        if (fill_q == md4_pkg::TOP_SLOT) begin
          state_d = md4_pkg::ST_PREP;
        end
      end
      md4_pkg::ST_PREP: state_d = md4_pkg::ST_COMP;
      md4_pkg::ST_COMP: begin
        if (step_q == md4_pkg::LAST_STEP) begin
          state_d = md4_pkg::ST_ADD;
        end
      end
      md4_pkg::ST_ADD: begin
        if (final_q) begin
          state_d = md4_pkg::ST_RESULT;
        end else if (closing_q) begin
          state_d = md4_pkg::ST_PAD;
        end else begin
          state_d = md4_pkg::ST_IDLE;
        end
      end
      md4_pkg::ST_RESULT: begin
        if (slot_free) begin
          state_d = md4_pkg::ST_IDLE;
        end
      end
      default: state_d = md4_pkg::ST_IDLE;
    endcase
  end

  // Block store write and read control.
  always_comb begin
    push      = 1'b0;
    push_word = 32'h0;
    raddr     = md4_pkg::msg_index(step_next);
    case (state_q)
      md4_pkg::ST_IDLE: begin
        push      = accept && !short_word;
        push_word = s_axis_tlast ? md4_pkg::tail_word(in_word, in_bytes) : in_word;
      end
      md4_pkg::ST_PAD: begin
        push = 1'b1;
        if (pad80_q) begin
          push_word = md4_pkg::PAD_WORD;
        end else if (len_hi_q) begin
          push_word = bit_len[63:32];
        end else if (fill_q == md4_pkg::LEN_SLOT) begin
          push_word = bit_len[31:0];
        end
      end
      md4_pkg::ST_PREP: raddr = md4_pkg::msg_index(6'd0);
      default: ;
    endcase
  end

  md4_ram #(
    .WIDTH(32),
    .DEPTH(16)
  ) u_block (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (fill_q),
    .wdata_i (push_word),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  md4_step u_step (
    .a_i    (wa_q),
    .b_i    (wb_q),
    .c_i    (wc_q),
    .d_i    (wd_q),
    .m_i    (rdata),
    .step_i (step_q),
    .a_o    (step_out)
  );

  // Control and chaining state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= md4_pkg::ST_IDLE;
      chain_q[0]   <= md4_pkg::INIT_A;
      chain_q[1]   <= md4_pkg::INIT_B;
      chain_q[2]   <= md4_pkg::INIT_C;
      chain_q[3]   <= md4_pkg::INIT_D;
      byte_total_q <= 64'h0;
      fill_q       <= 4'h0;
      step_q       <= 6'h0;
      pad80_q      <= 1'b0;
      len_hi_q     <= 1'b0;
      final_q      <= 1'b0;
      closing_q    <= 1'b0;
      err_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (push) begin
        fill_q <= fill_q + 4'd1;
      end
      if (state_q == md4_pkg::ST_RESULT && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        md4_pkg::ST_IDLE: begin
          if (accept) begin
            if (short_word) begin
              err_q <= 1'b1;
            end else begin
              byte_total_q <= byte_total_q + {61'h0, in_bytes};
              if (s_axis_tlast) begin
                closing_q <= 1'b1;
                pad80_q   <= (in_bytes == md4_pkg::FULL_BYTES);
              end
            end
          end
        end
        md4_pkg::ST_PAD: begin
          if (pad80_q) begin
            pad80_q <= 1'b0;
          end else if (len_hi_q) begin
            len_hi_q <= 1'b0;
            final_q  <= 1'b1;
          end else if (fill_q == md4_pkg::LEN_SLOT) begin
            len_hi_q <= 1'b1;
          end
        end
        md4_pkg::ST_PREP: step_q <= 6'h0;
        md4_pkg::ST_COMP: begin
          step_q <= (step_q == md4_pkg::LAST_STEP) ? 6'h0 : step_next;
        end
        md4_pkg::ST_ADD: begin
          chain_q[0] <= chain_q[0] + wa_q;
          chain_q[1] <= chain_q[1] + wb_q;
          chain_q[2] <= chain_q[2] + wc_q;
          chain_q[3] <= chain_q[3] + wd_q;
        end
        md4_pkg::ST_RESULT: begin
          if (slot_free) begin
            if (err_q) begin
              err_q <= 1'b0;
            end else begin
              chain_q[0]   <= md4_pkg::INIT_A;
              chain_q[1]   <= md4_pkg::INIT_B;
              chain_q[2]   <= md4_pkg::INIT_C;
              chain_q[3]   <= md4_pkg::INIT_D;
              byte_total_q <= 64'h0;
              fill_q       <= 4'h0;
              closing_q    <= 1'b0;
              final_q      <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers rotate (a, b, c, d) <- (d, new, b, c) every step; the result beat is captured here too.
  always_ff @(posedge clk_i) begin
    case (state_q)
      md4_pkg::ST_PREP: begin
        wa_q <= chain_q[0];
        wb_q <= chain_q[1];
        wc_q <= chain_q[2];
        wd_q <= chain_q[3];
      end
      md4_pkg::ST_COMP: begin
        wa_q <= wd_q;
        wb_q <= step_out;
        wc_q <= wb_q;
        wd_q <= wc_q;
      end
      default: ;
    endcase
    if (state_q == md4_pkg::ST_RESULT && slot_free) begin
      out_err_q  <= err_q;
      out_low_q  <= err_q ? 64'h0 : {chain_q[1], chain_q[0]};
      out_high_q <= err_q ? 64'h0 : {chain_q[3], chain_q[2]};
    end
  end

endmodule

`default_nettype wire

[src/md4_hash_engine_chk.sv]
// Port-level checker for the MD4 hash engine, bound to the top level.
// Sees only the top-level ports; no package dependency.
`default_nettype none

module md4_hash_engine_chk (
  input wire         clk_i,
  input wire         rst_ni,
  input wire         s_axis_tvalid,
  input wire         s_axis_tready,
  input wire [39:0]  s_axis_tdata,
  input wire         s_axis_tlast,
  input wire         m_axis_tvalid,
  input wire         m_axis_tready,
  input wire [127:0] m_axis_tdata,
  input wire         m_axis_tuser
);

  // A stalled result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // An error beat never carries a digest.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 128'h0)
    else $error("error beat with nonzero digest");

  // A full word that does not end the message produces no result.
  a_full_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tlast && s_axis_tdata[34] |=>
      !$rose(m_axis_tvalid))
    else $error("result beat after a plain data word");

  // The engine is busy padding or compressing after the last word of a message.
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input ready right after a last word");

endmodule

bind md4_hash_engine md4_hash_engine_chk u_md4_chk (.*);

`default_nettype wire

[sim/md4_hash_engine_test.sv]
// Self-checking bench for md4_hash_engine: streams random and directed messages,
// predicts every digest and dropped-word flag in software and checks each output beat.
// Depends on md4_pkg and md4_hash_engine.
`timescale 1ns / 1ps

module md4_hash_engine_test;

  typedef struct packed {
    bit [63:0] low;
    bit [63:0] high;
    bit        flag;
  } digest_t;

  // Software MD4 engine that holds the digests still owed by the block.
  class md4_digest_tracker;
    bit [31:0]   chain [4];
    bit [31:0]   block [16];
    bit [63:0]   total;
    bit [3:0]    fill;
    int unsigned rot_amt [3][4] = '{'{3, 7, 11, 19}, '{3, 5, 9, 13}, '{3, 9, 11, 15}};
    digest_t     digests_due [$];
    int          mismatches;
    int          digests_seen;
    int          flags_seen;

    function new();
      mismatches   = 0;
      digests_seen = 0;
      flags_seen   = 0;
      restart();
    endfunction

    function void restart();
      chain[0] = md4_pkg::INIT_A;
      chain[1] = md4_pkg::INIT_B;
      chain[2] = md4_pkg::INIT_C;
      chain[3] = md4_pkg::INIT_D;
      total    = '0;
      fill     = '0;
    endfunction

    function bit [31:0] rotl(bit [31:0] v, int unsigned s);
      return (v << s) | (v >> (32 - s));
    endfunction

    function void compress();
      bit [31:0] w [4];
      bit [31:0] x;
      bit [31:0] y;
      bit [31:0] z;
      bit [31:0] f;
      bit [31:0] k;
      bit [3:0]  j;
      bit [3:0]  idx;
      int        rnd;
      int        t;
      for (int i = 0; i < 4; i++) w[i] = chain[i];
      for (int s = 0; s < 48; s++) begin
        rnd = s / 16;
        j   = 4'(s % 16);
        // The register written rotates A, D, C, B across the four steps of a group.
        t   = (4 - (s % 4)) % 4;
        x   = w[(t + 1) % 4];
        y   = w[(t + 2) % 4];
        z   = w[(t + 3) % 4];
        case (rnd)
          0: begin
            f   = z ^ (x & (y ^ z));
            k   = '0;
            idx = j;
          end
          1: begin
            f   = (x & y) | (x & z) | (y & z);
            k   = md4_pkg::K_ROUND2;
            idx = {j[1:0], j[3:2]};
          end
          default: begin
            f   = x ^ y ^ z;
            k   = md4_pkg::K_ROUND3;
            idx = {j[0], j[1], j[2], j[3]};
          end
        endcase
        w[t] = rotl(w[t] + f + block[idx] + k, rot_amt[rnd][s % 4]);
      end
      for (int i = 0; i < 4; i++) chain[i] += w[i];
    endfunction

    function void store(bit [31:0] w);
      block[fill] = w;
      fill        = fill + 4'd1;
      if (fill == 4'd0) compress();
    endfunction

    // Called for every accepted input beat.
    function void take_word(bit [31:0] data, bit [2:0] count, bit last);
      digest_t   d;
      bit [2:0]  nb;
      bit [31:0] mask;
      bit [63:0] bits;
      nb = (count > md4_pkg::FULL_BYTES) ? md4_pkg::FULL_BYTES : count;
      if (!last) begin
        if (nb < md4_pkg::FULL_BYTES) begin
          d.low  = '0;
          d.high = '0;
          d.flag = 1'b1;
          digests_due.push_back(d);
        end else begin
          total += 64'd4;
          store(data);
        end
        return;
      end
      total += 64'(nb);
      if (nb == md4_pkg::FULL_BYTES) begin
        store(data);
        store(md4_pkg::PAD_WORD);
      end else begin
        mask = (nb == 3'd0) ? 32'h0 : (32'hFFFFFFFF >> (32 - 8 * nb));
        store((data & mask) | (md4_pkg::PAD_WORD << (8 * nb)));
      end
      while (fill != md4_pkg::LEN_SLOT) store('0);
      bits = total << 3;
      store(bits[31:0]);
      store(bits[63:32]);
      d.low  = {chain[1], chain[0]};
      d.high = {chain[3], chain[2]};
      d.flag = 1'b0;
      digests_due.push_back(d);
      restart();
    endfunction

    function void check_digest(bit [63:0] low, bit [63:0] high, bit flag);
      digest_t d;
      if (digests_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected output beat low=%h high=%h error=%b", $time, low, high, flag);
        return;
      end
      d = digests_due.pop_front();
      if (d.flag) flags_seen++;
      else digests_seen++;
      if (low !== d.low) begin
        mismatches++;
        $display("%0t: digest_low expected %h, got %h", $time, d.low, low);
      end
      if (high !== d.high) begin
        mismatches++;
        $display("%0t: digest_high expected %h, got %h", $time, d.high, high);
      end
      if (flag !== d.flag) begin
        mismatches++;
        $display("%0t: error expected %b, got %b", $time, d.flag, flag);
      end
    endfunction

    function int pending();
      return digests_due.size();
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;
  logic         m_axis_tuser;

  md4_digest_tracker tracker = new();
  int                words_sent = 0;
  int                messages_sent = 0;
  bit                calm = 1'b0;
  bit                hold_request = 1'b0;

  md4_hash_engine u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Output beats are checked before the input beat of the same edge is absorbed.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        tracker.check_digest(m_axis_tdata[63:0], m_axis_tdata[127:64], m_axis_tuser);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        tracker.take_word(s_axis_tdata[31:0], s_axis_tdata[34:32], s_axis_tlast);
      end
    end
  end

  // Digest receiver with random stalls and one long hold-off that backs up the engine.
  initial begin
    int unsigned hold_left;
    bit          hold_started;
    hold_left    = 0;
    hold_started = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request && !hold_started) begin
        hold_started = 1'b1;
        hold_left    = 1500;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 13);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [31:0] pick_data();
    case ($urandom_range(15))
      0:       return 32'h00000000;
      1:       return 32'hFFFFFFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_word(input logic [31:0] data, input logic [2:0] count, input logic last);
    if (!calm && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, count, data};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  // A message of full words ending in a last word of any byte count, with the
  // occasional short word thrown in that must be dropped and flagged.
  task automatic send_message(input int nwords);
    for (int i = 0; i < nwords - 1; i++) begin
      if ($urandom_range(99) < 4) send_word(pick_data(), 3'($urandom_range(3)), 1'b0);
      send_word(pick_data(),
                ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : md4_pkg::FULL_BYTES,
                1'b0);
    end
    send_word(pick_data(), 3'($urandom_range(7)), 1'b1);
    messages_sent++;
  endtask

  initial begin
    int r;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    rst_ni        <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty message, short tails with junk above the valid bytes, oversized count.
    send_word(32'hFFFFFFFF, 3'd0, 1'b1);
    send_word(32'hFFFFFF61, 3'd1, 1'b1);
    send_word(32'hFFFF6261, 3'd2, 1'b1);
    send_word(32'hFF636261, 3'd3, 1'b1);
    send_word(32'hFFFFFFFF, 3'd7, 1'b1);
    // Short words without the last mark are dropped.
    send_word(32'hFFFFFFFF, 3'd0, 1'b0);
    send_word(32'h00FFFFFF, 3'd3, 1'b0);
    // Oversized counts on full words, then an empty closing word.
    send_word(32'h00000000, 3'd5, 1'b0);
    send_word(32'hFFFFFFFF, 3'd6, 1'b0);
    send_word(32'hFFFFFFFF, 3'd0, 1'b1);
    // A 64-byte message: the pad has to go into a block of its own.
    for (int i = 0; i < 15; i++) send_word(i[0] ? 32'hFFFFFFFF : 32'h00000000, 3'd4, 1'b0);
    send_word(32'hA5A5A5A5, 3'd4, 1'b1);
    messages_sent += 7;

    while (words_sent < 1675) begin
      if (messages_sent == 12) hold_request = 1'b1;
      calm = (messages_sent >= 40 && messages_sent < 55);
      r = $urandom_range(99);
      if (r < 5) send_message($urandom_range(130, 41));
      else if (r < 35) send_message($urandom_range(40, 13));
      else send_message($urandom_range(12, 1));
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Streamed %0d words in %0d messages, including block-boundary tails.",
             words_sent, messages_sent);
    $display("Checked %0d digests and %0d dropped-word flags; %0d mismatches.",
             tracker.digests_seen, tracker.flags_seen, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
